/* design/rob_pkg.sv */
// shared types, field widths and codes of the raster-op blitter
// the raster-op combine function lives here too
// no dependencies
package rob_pkg;

	// default framebuffer bounds
	localparam int DEF_MAX_WIDTH  = 512;
	localparam int DEF_MAX_HEIGHT = 512;

	// fixed field widths
	localparam int PIX_W      = 32;
	localparam int ADDR_W     = 18;
	localparam int SIZE_W     = 10;
	localparam int POS_W      = 9;
	localparam int OP_W       = 3;
	localparam int ACT_W      = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;

	// item actions
	typedef enum logic [ACT_W-1:0] {
		ACT_BLIT = 2'd0,
		ACT_FILL = 2'd1,
		ACT_READ = 2'd2
	} action_t;

	// raster operations
	typedef enum logic [OP_W-1:0] {
		ROP_COPY    = 3'd0,
		ROP_OR      = 3'd1,
		ROP_AND     = 3'd2,
		ROP_XOR     = 3'd3,
		ROP_INV_DST = 3'd4,
		ROP_INV_SRC = 3'd5
	} rop_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LINE_WIDTH   = 3'd0,
		CFG_FRAME_HEIGHT = 3'd1,
		CFG_DEST_LEFT    = 3'd2,
		CFG_DEST_TOP     = 3'd3,
		CFG_RECT_WIDTH   = 3'd4,
		CFG_RECT_HEIGHT  = 3'd5,
		CFG_RASTER_OP    = 3'd6
	} cfg_reg_t;

	// input transaction
	typedef struct packed {
		logic [ACT_W-1:0]  action;
		logic [PIX_W-1:0]  pixel;
		logic [ADDR_W-1:0] address;
	} item_t;

	// output transaction
	typedef struct packed {
		logic [PIX_W-1:0] read_data;
		logic             rect_done;
		logic             clipped;
	} result_t;

	// raw configuration register contents
	typedef struct packed {
		logic [SIZE_W-1:0] line_width;
		logic [SIZE_W-1:0] frame_height;
		logic [POS_W-1:0]  dest_left;
		logic [POS_W-1:0]  dest_top;
		logic [SIZE_W-1:0] rect_width;
		logic [SIZE_W-1:0] rect_height;
		logic [OP_W-1:0]   raster_op;
	} cfg_t;

	// request from address generation to the read-modify-write stage
	typedef struct packed {
		logic             valid;
		logic [ACT_W-1:0] action;
		logic [PIX_W-1:0] pixel;
		logic             clipped;
		logic             done;
	} req_t;

	// new destination pixel; unknown ops keep the destination
	function automatic logic [PIX_W-1:0] rop_combine(input logic [OP_W-1:0] op,
		input logic [PIX_W-1:0] src, input logic [PIX_W-1:0] dst);
		logic [PIX_W-1:0] res;
		unique case (rop_t'(op))
			ROP_COPY:    res = src;
			ROP_OR:      res = dst | src;
			ROP_AND:     res = dst & src;
			ROP_XOR:     res = dst ^ src;
			ROP_INV_DST: res = ~dst;
			ROP_INV_SRC: res = ~src;
			default:     res = dst;
		endcase
		return res;
	endfunction

endpackage

/* design/rob_cfg.sv */
// configuration registers of the raster-op blitter with write decode
// a valid write also restarts the rectangle counters
// depends on rob_pkg
module rob_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [rob_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rob_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output rob_pkg::cfg_t                    cfg,
	output logic                             cfg_clear
);

	rob_pkg::cfg_t cfg_q;

	// index decode
	always_comb begin
		unique case (rob_pkg::cfg_reg_t'(cfg_index))
			rob_pkg::CFG_LINE_WIDTH,
			rob_pkg::CFG_FRAME_HEIGHT,
			rob_pkg::CFG_DEST_LEFT,
			rob_pkg::CFG_DEST_TOP,
			rob_pkg::CFG_RECT_WIDTH,
			rob_pkg::CFG_RECT_HEIGHT,
			rob_pkg::CFG_RASTER_OP: cfg_clear = cfg_wr_en;
			default:                cfg_clear = 1'b0;
		endcase
	end

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.line_width   <= rob_pkg::SIZE_W'(512);
			cfg_q.frame_height <= rob_pkg::SIZE_W'(512);
			cfg_q.dest_left    <= '0;
			cfg_q.dest_top     <= '0;
			cfg_q.rect_width   <= rob_pkg::SIZE_W'(1);
			cfg_q.rect_height  <= rob_pkg::SIZE_W'(1);
			cfg_q.raster_op    <= rob_pkg::ROP_COPY;
		end else if (cfg_wr_en) begin
			unique case (rob_pkg::cfg_reg_t'(cfg_index))
				rob_pkg::CFG_LINE_WIDTH:   cfg_q.line_width   <= cfg_wdata;
				rob_pkg::CFG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_wdata;
				rob_pkg::CFG_DEST_LEFT:    cfg_q.dest_left    <= cfg_wdata[rob_pkg::POS_W-1:0];
				rob_pkg::CFG_DEST_TOP:     cfg_q.dest_top     <= cfg_wdata[rob_pkg::POS_W-1:0];
				rob_pkg::CFG_RECT_WIDTH:   cfg_q.rect_width   <= cfg_wdata;
				rob_pkg::CFG_RECT_HEIGHT:  cfg_q.rect_height  <= cfg_wdata;
				rob_pkg::CFG_RASTER_OP:    cfg_q.raster_op    <= cfg_wdata[rob_pkg::OP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* design/rob_addr_gen.sv */
// rectangle counters, clipping and pixel address generation
// accept stage computes coordinates, stage 1 forms the linear address
// depends on rob_pkg
module rob_addr_gen #(
	parameter  int MAX_WIDTH  = rob_pkg::DEF_MAX_WIDTH,
	parameter  int MAX_HEIGHT = rob_pkg::DEF_MAX_HEIGHT,
	localparam int AW         = $clog2(MAX_WIDTH * MAX_HEIGHT),
	localparam int TW         = $clog2(MAX_WIDTH * MAX_HEIGHT + 1)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  rob_pkg::cfg_t  cfg,
	input  logic           cfg_clear,
	input  logic           adv,
	input  logic           accept,
	input  rob_pkg::item_t item,
	output rob_pkg::req_t  req,
	output logic [AW-1:0]  req_addr,
	output logic [TW-1:0]  req_total
);

	localparam int COLW = $clog2(MAX_WIDTH);
	localparam int ROWW = $clog2(MAX_HEIGHT);
	localparam int WW   = $clog2(MAX_WIDTH + 1);
	localparam int HW   = $clog2(MAX_HEIGHT + 1);
	localparam int WCW  = (rob_pkg::SIZE_W > WW) ? rob_pkg::SIZE_W : WW;
	localparam int HCW  = (rob_pkg::SIZE_W > HW) ? rob_pkg::SIZE_W : HW;
	localparam int XW   = ((COLW > rob_pkg::POS_W) ? COLW : rob_pkg::POS_W) + 1;
	localparam int YW   = ((ROWW > rob_pkg::POS_W) ? ROWW : rob_pkg::POS_W) + 1;
	localparam int PRW  = YW + WW;
	localparam int TCW  = (WW + HW > rob_pkg::ADDR_W) ? WW + HW : rob_pkg::ADDR_W;

	// size saturation into 1..max
	function automatic logic [WW-1:0] clamp_w(input logic [rob_pkg::SIZE_W-1:0] v);
		logic [WCW-1:0] vx;
		logic [WW-1:0]  r;
		vx = WCW'(v);
		if (vx == '0)
			r = WW'(1);
		else if (vx > WCW'(MAX_WIDTH))
			r = WW'(MAX_WIDTH);
		else
			r = WW'(vx);
		return r;
	endfunction

	function automatic logic [HW-1:0] clamp_h(input logic [rob_pkg::SIZE_W-1:0] v);
		logic [HCW-1:0] vx;
		logic [HW-1:0]  r;
		vx = HCW'(v);
		if (vx == '0)
			r = HW'(1);
		else if (vx > HCW'(MAX_HEIGHT))
			r = HW'(MAX_HEIGHT);
		else
			r = HW'(vx);
		return r;
	endfunction

	logic [WW-1:0]   w, rw;
	logic [HW-1:0]   h, rh;
	logic [COLW-1:0] col_q;
	logic [ROWW-1:0] row_q;
	logic [COLW:0]   col_inc;
	logic [ROWW:0]   row_inc;
	logic            col_wrap, row_wrap, blit_in;
	logic [XW-1:0]   x0;
	logic [YW-1:0]   y0;
	logic            clip0;

	logic                            v_s1;
	logic [rob_pkg::ACT_W-1:0]       act_s1;
	logic [rob_pkg::PIX_W-1:0]       pixel_s1;
	logic [rob_pkg::ADDR_W-1:0]      address_s1;
	logic [XW-1:0]                   x_s1;
	logic [YW-1:0]                   y_s1;
	logic                            bclip_s1;
	logic                            done_s1;

	logic [PRW-1:0] prod, sum;
	logic [TCW-1:0] total;
	logic           rclip;

	// effective sizes
	assign w  = clamp_w(cfg.line_width);
	assign h  = clamp_h(cfg.frame_height);
	assign rw = clamp_w(cfg.rect_width);
	assign rh = clamp_h(cfg.rect_height);

	// destination coordinates and wrap of the running counters
	assign blit_in  = rob_pkg::action_t'(item.action) == rob_pkg::ACT_BLIT;
	assign col_inc  = (COLW+1)'(col_q) + (COLW+1)'(1);
	assign row_inc  = (ROWW+1)'(row_q) + (ROWW+1)'(1);
	assign col_wrap = col_inc >= (COLW+1)'(rw);
	assign row_wrap = row_inc >= (ROWW+1)'(rh);
	assign x0       = XW'(cfg.dest_left) + XW'(col_q);
	assign y0       = YW'(cfg.dest_top) + YW'(row_q);
	assign clip0    = (x0 >= XW'(w)) || (y0 >= YW'(h));

	// rectangle counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_clear) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept && blit_in) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : ROWW'(row_inc);
			end else begin
				col_q <= COLW'(col_inc);
			end
		end
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (adv)
			v_s1 <= accept;
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (adv && accept) begin
			act_s1     <= item.action;
			pixel_s1   <= item.pixel;
			address_s1 <= item.address;
			x_s1       <= x0;
			y_s1       <= y0;
			bclip_s1   <= clip0;
			done_s1    <= blit_in && col_wrap && row_wrap;
		end
	end

	// linear address, buffer size and read bound
	assign prod  = PRW'(y_s1) * PRW'(w);
	assign sum   = prod + PRW'(x_s1);
	assign total = TCW'(w) * TCW'(h);
	assign rclip = TCW'(address_s1) >= total;

	always_comb begin
		req.valid  = v_s1;
		req.action = act_s1;
		req.pixel  = pixel_s1;
		req.done   = done_s1;
		unique case (rob_pkg::action_t'(act_s1))
			rob_pkg::ACT_BLIT: begin
				req.clipped = bclip_s1;
				req_addr    = AW'(sum);
			end
			rob_pkg::ACT_READ: begin
				req.clipped = rclip;
				req_addr    = AW'(address_s1);
			end
			default: begin
				req.clipped = 1'b0;
				req_addr    = AW'(sum);
			end
		endcase
	end

	assign req_total = TW'(total);

endmodule

/* design/rob_rmw.sv */
// frame memory with read-modify-write stage, fill sweep and result register
// forwards the last write to a read of the same pixel issued in the same cycle
// depends on rob_pkg
module rob_rmw #(
	parameter  int MAX_WIDTH  = rob_pkg::DEF_MAX_WIDTH,
	parameter  int MAX_HEIGHT = rob_pkg::DEF_MAX_HEIGHT,
	localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT,
	localparam int AW         = $clog2(MAX_WIDTH * MAX_HEIGHT),
	localparam int TW         = $clog2(MAX_WIDTH * MAX_HEIGHT + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  rob_pkg::req_t                req,
	input  logic [AW-1:0]                req_addr,
	input  logic [TW-1:0]                req_total,
	input  logic [rob_pkg::OP_W-1:0]     raster_op,
	output logic                         busy,
	output logic                         result_valid,
	output rob_pkg::result_t             result
);

	logic [rob_pkg::PIX_W-1:0] mem [DEPTH];
	logic [rob_pkg::PIX_W-1:0] mem_rd_q;
	logic                      rd_en;
	logic                      mem_we;
	logic [AW-1:0]             mem_waddr;
	logic [rob_pkg::PIX_W-1:0] mem_wdata;

	logic                      v_s2;
	logic [rob_pkg::ACT_W-1:0] act_s2;
	logic [rob_pkg::PIX_W-1:0] pixel_s2;
	logic [AW-1:0]             addr_s2;
	logic                      clip_s2;
	logic                      done_s2;
	logic [TW-1:0]             total_s2;

	logic                      fwd_hit_q;
	logic [rob_pkg::PIX_W-1:0] fwd_data_q;
	logic [rob_pkg::PIX_W-1:0] rdata;
	logic                      wr_s2;
	logic [rob_pkg::PIX_W-1:0] wdata_s2;
	logic                      fill_s2, read_s2;

	logic                      sweep_q;
	logic [AW-1:0]             sweep_addr_q;
	logic [AW-1:0]             sweep_last_q;
	logic [rob_pkg::PIX_W-1:0] color_q;

	logic                      result_valid_q;
	rob_pkg::result_t          result_q;
	rob_pkg::result_t          result_d;

	// read only for in-bounds blits and reads
	assign rd_en = adv && req.valid && !req.clipped &&
		((rob_pkg::action_t'(req.action) == rob_pkg::ACT_BLIT) ||
		 (rob_pkg::action_t'(req.action) == rob_pkg::ACT_READ));

	// stage 2 decode and modify
	assign fill_s2  = v_s2 && (rob_pkg::action_t'(act_s2) == rob_pkg::ACT_FILL);
	assign read_s2  = v_s2 && (rob_pkg::action_t'(act_s2) == rob_pkg::ACT_READ);
	assign wr_s2    = v_s2 && (rob_pkg::action_t'(act_s2) == rob_pkg::ACT_BLIT) && !clip_s2;
	assign rdata    = fwd_hit_q ? fwd_data_q : mem_rd_q;
	assign wdata_s2 = rob_pkg::rop_combine(raster_op, pixel_s2, rdata);

	// write port: sweep owns it while running, pipeline is empty then
	always_comb begin
		if (sweep_q) begin
			mem_we    = 1'b1;
			mem_waddr = sweep_addr_q;
			mem_wdata = color_q;
		end else begin
			mem_we    = adv && wr_s2;
			mem_waddr = addr_s2;
			mem_wdata = wdata_s2;
		end
	end

	// frame memory
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		if (rd_en)
			mem_rd_q <= mem[req_addr];
	end

	// stage 2 valid and forwarding flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2      <= 1'b0;
			fwd_hit_q <= 1'b0;
		end else if (adv) begin
			v_s2      <= req.valid;
			fwd_hit_q <= wr_s2 && (addr_s2 == req_addr);
		end
	end

	// stage 2 payload
	always_ff @(posedge clk) begin
		if (adv) begin
			act_s2     <= req.action;
			pixel_s2   <= req.pixel;
			addr_s2    <= req_addr;
			clip_s2    <= req.clipped;
			done_s2    <= req.done;
			total_s2   <= req_total;
			fwd_data_q <= wdata_s2;
		end
	end

	// clear after reset, fill on request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q      <= 1'b1;
			sweep_addr_q <= '0;
			sweep_last_q <= AW'(DEPTH - 1);
			color_q      <= '0;
		end else if (sweep_q) begin
			sweep_addr_q <= sweep_addr_q + AW'(1);
			if (sweep_addr_q == sweep_last_q)
				sweep_q <= 1'b0;
		end else if (adv && fill_s2) begin
			sweep_q      <= 1'b1;
			sweep_addr_q <= '0;
			sweep_last_q <= AW'(total_s2 - TW'(1));
			color_q      <= pixel_s2;
		end
	end

	assign busy = sweep_q || fill_s2;

	// result fields
	always_comb begin
		result_d.read_data = (read_s2 && !clip_s2) ? rdata : '0;
		result_d.rect_done = done_s2;
		result_d.clipped   = clip_s2;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid_q <= 1'b0;
		else if (adv)
			result_valid_q <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (adv)
			result_q <= result_d;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

/* design/raster_op_blitter_top.sv */
// Raster-op blitter over a framebuffer of 32-bit pixels held in one on-chip RAM.
// Items enter on item_valid/item_ready; each gives exactly one result on
// result_valid/result_ready, in order. Registers are written through
// cfg_wr_en/cfg_index/cfg_wdata; the user must write them only while no
// transaction is in flight, which the block does not enforce; any write to a
// known register restarts the rectangle at its top left corner. Blit and read
// items: one transaction per cycle unless result_ready stalls or a fill runs.
// Each blit pixel is a read-modify-write of one RAM entry; the single read and
// single write port set the rate, and a write forwards to a read of the same
// pixel issued in the same cycle. Fill item: its result is registered as the
// RAM write port starts to sweep the clamped line_width*frame_height entries,
// one per cycle, with item_ready low. Reset: counters and registers take their
// reset values, then the same sweep clears all MAX_WIDTH*MAX_HEIGHT entries
// (262144 by default) with item_ready low; configuration writes are taken
// during this time. A stall on result_ready holds the whole pipeline; up to three
// transactions (stage 1, stage 2 and the result register) are held in flight.
// depends on rob_pkg, rob_cfg, rob_addr_gen, rob_rmw
module raster_op_blitter_top #(
	parameter int MAX_WIDTH  = rob_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = rob_pkg::DEF_MAX_HEIGHT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [rob_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rob_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  rob_pkg::item_t                  item,
	output logic                            result_valid,
	input  logic                            result_ready,
	output rob_pkg::result_t                result
);

	localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);
	localparam int TW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

	rob_pkg::cfg_t cfg;
	logic          cfg_clear;
	rob_pkg::req_t req;
	logic [AW-1:0] req_addr;
	logic [TW-1:0] req_total;
	logic          adv, accept, rmw_busy, fill_s1;

	// pipeline moves whenever the result register can take a transaction
	assign adv        = !result_valid || result_ready;
	assign fill_s1    = req.valid && (rob_pkg::action_t'(req.action) == rob_pkg::ACT_FILL);
	assign item_ready = adv && !rmw_busy && !fill_s1;
	assign accept     = item_valid && item_ready;

	rob_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg),
		.cfg_clear (cfg_clear)
	);

	rob_addr_gen #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_addr_gen (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cfg_clear (cfg_clear),
		.adv       (adv),
		.accept    (accept),
		.item      (item),
		.req       (req),
		.req_addr  (req_addr),
		.req_total (req_total)
	);

	rob_rmw #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_rmw (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.req          (req),
		.req_addr     (req_addr),
		.req_total    (req_total),
		.raster_op    (cfg.raster_op),
		.busy         (rmw_busy),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

/* tb/blit_checker.sv */
`timescale 1ns / 100ps
// checker for the raster-op blitter: keeps its own frame store, counters and
// registers, predicts one result per accepted item and compares them in order
// depends on rob_pkg
module blit_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [rob_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rob_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                           item_valid,
	input  logic                           item_ready,
	input  rob_pkg::item_t                 item,
	input  logic                           result_valid,
	input  logic                           result_ready,
	input  rob_pkg::result_t               result,
	output int                             errors,
	output int                             pending
);
	import rob_pkg::*;

	localparam int FB_W       = DEF_MAX_WIDTH;
	localparam int FB_H       = DEF_MAX_HEIGHT;
	localparam int REPORT_MAX = 10;

	logic [PIX_W-1:0] frame_px [FB_W*FB_H];
	cfg_t             regs;
	int               col_cnt;
	int               row_cnt;
	int               mismatches;
	result_t          awaited_results [$];

	// sizes of zero count as one, oversize saturates
	function automatic int fit_dim(int v, int hi);
		return (v < 1) ? 1 : ((v > hi) ? hi : v);
	endfunction

	// new destination pixel for one raster op
	function automatic logic [PIX_W-1:0] blend_pixel(logic [OP_W-1:0] op,
		logic [PIX_W-1:0] src, logic [PIX_W-1:0] dst);
		case (op)
			ROP_COPY:    return src;
			ROP_OR:      return dst | src;
			ROP_AND:     return dst & src;
			ROP_XOR:     return dst ^ src;
			ROP_INV_DST: return ~dst;
			ROP_INV_SRC: return ~src;
			default:     return dst;
		endcase
	endfunction

	// register write; a known register restarts the rectangle
	function automatic void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		bit known;
		known = 1'b1;
		case (idx)
			CFG_LINE_WIDTH:   regs.line_width   = data;
			CFG_FRAME_HEIGHT: regs.frame_height = data;
			CFG_DEST_LEFT:    regs.dest_left    = data[POS_W-1:0];
			CFG_DEST_TOP:     regs.dest_top     = data[POS_W-1:0];
			CFG_RECT_WIDTH:   regs.rect_width   = data;
			CFG_RECT_HEIGHT:  regs.rect_height  = data;
			CFG_RASTER_OP:    regs.raster_op    = data[OP_W-1:0];
			default:          known = 1'b0;
		endcase
		if (known) begin
			col_cnt = 0;
			row_cnt = 0;
		end
	endfunction

	// update the mirrored state for one transaction and return its result
	function automatic result_t apply_item(item_t it);
		result_t r;
		int      w;
		int      h;
		int      total;
		int      x;
		int      y;
		int      idx;
		r     = '0;
		w     = fit_dim(regs.line_width, FB_W);
		h     = fit_dim(regs.frame_height, FB_H);
		total = w * h;
		case (it.action)
			ACT_BLIT: begin
				x = regs.dest_left + col_cnt;
				y = regs.dest_top + row_cnt;
				// writes outside the frame are dropped, counters still move
				if (x >= w || y >= h) begin
					r.clipped = 1'b1;
				end else begin
					idx = y * w + x;
					frame_px[idx] = blend_pixel(regs.raster_op, it.pixel, frame_px[idx]);
				end
				col_cnt++;
				if (col_cnt >= fit_dim(regs.rect_width, FB_W)) begin
					col_cnt = 0;
					row_cnt++;
					if (row_cnt >= fit_dim(regs.rect_height, FB_H)) begin
						row_cnt = 0;
						r.rect_done = 1'b1;
					end
				end
			end
			ACT_FILL: begin
				for (int i = 0; i < total; i++) frame_px[i] = it.pixel;
			end
			ACT_READ: begin
				if (it.address < total) r.read_data = frame_px[it.address];
				else r.clipped = 1'b1;
			end
			default: ;
		endcase
		return r;
	endfunction

	// watch both channels and the register port
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			foreach (frame_px[i]) frame_px[i] = '0;
			regs              = '0;
			regs.line_width   = 10'd512;
			regs.frame_height = 10'd512;
			regs.rect_width   = 10'd1;
			regs.rect_height  = 10'd1;
			regs.raster_op    = ROP_COPY;
			col_cnt           = 0;
			row_cnt           = 0;
			mismatches        = 0;
			awaited_results.delete();
			errors  <= 0;
			pending <= 0;
		end else begin
			if (cfg_wr_en) write_reg(cfg_index, cfg_wdata);
			if (item_valid && item_ready) awaited_results.push_back(apply_item(item));
			if (result_valid && result_ready) begin
				if (awaited_results.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("checker: unexpected result data=%h done=%b clip=%b",
							result.read_data, result.rect_done, result.clipped);
				end else begin
					want = awaited_results.pop_front();
					if (want.read_data !== result.read_data ||
						want.rect_done !== result.rect_done ||
						want.clipped !== result.clipped) begin
						mismatches++;
						if (mismatches <= REPORT_MAX)
							$display("checker: mismatch exp data=%h done=%b clip=%b, got data=%h done=%b clip=%b",
								want.read_data, want.rect_done, want.clipped,
								result.read_data, result.rect_done, result.clipped);
					end
				end
			end
			errors  <= mismatches;
			pending <= awaited_results.size();
		end
	end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// testbench top for raster_op_blitter_top: clock, reset, register writes,
// directed and random transactions with idling on both sides, and the verdict
// depends on rob_pkg, blit_checker and the blitter rtl
module tb;
	import rob_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
	localparam logic [ACT_W-1:0]     ACT_NONE  = 2'd3;
	localparam int FILL_MAX   = 4096;
	localparam int BURST_MAX  = 64;
	localparam int RAND_ITEMS = 1100;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  cfg_wr_en    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata    = '0;
	logic                  item_valid   = 1'b0;
	logic                  item_ready;
	item_t                 item         = '0;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	result_t               result;
	int                    errors;
	int                    pending;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int items_sent     = 0;

	// clamped copy of the registers, only used to shape stimulus
	int sh_w    = 512;
	int sh_h    = 512;
	int sh_left = 0;
	int sh_top  = 0;
	int sh_rw   = 1;
	int sh_rh   = 1;

	raster_op_blitter_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	blit_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.errors       (errors),
		.pending      (pending)
	);

	// 2 ns clock
	always #1 clk = ~clk;

	// receiver stalls at random
	always @(posedge clk) begin
		result_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// run limit
	initial begin
		#20_000_000;
		$display("tb: FAIL");
		$finish;
	end

	function automatic int clamp_dim(int v, int hi);
		return (v < 1) ? 1 : ((v > hi) ? hi : v);
	endfunction

	// pixel with the all-zero and all-one patterns mixed in
	function automatic logic [PIX_W-1:0] rand_pixel();
		case ($urandom_range(7))
			0:       return '0;
			1:       return '1;
			default: return $urandom;
		endcase
	endfunction

	// size register value: small, zero, mid-range, or at and past the top of the range
	function automatic int rand_dim(bit wide, int small_hi);
		if (wide) begin
			case ($urandom_range(3))
				0:       return 512;
				1:       return $urandom_range(513, 1023);
				2:       return 1023;
				default: return $urandom_range(65, 511);
			endcase
		end
		return ($urandom_range(11) == 0) ? 0 : $urandom_range(1, small_hi);
	endfunction

	// linear index of a random pixel of the current rectangle
	function automatic logic [ADDR_W-1:0] rect_addr();
		int a;
		a = (sh_top + $urandom_range(sh_rh - 1)) * sh_w + sh_left + $urandom_range(sh_rw - 1);
		return a[ADDR_W-1:0];
	endfunction

	// one register write; the caller lowers the enable after the last one
	task automatic set_reg(logic [CFG_IDX_W-1:0] idx, int value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value[CFG_DATA_W-1:0];
		case (idx)
			CFG_LINE_WIDTH:   sh_w    = clamp_dim(value & 1023, DEF_MAX_WIDTH);
			CFG_FRAME_HEIGHT: sh_h    = clamp_dim(value & 1023, DEF_MAX_HEIGHT);
			CFG_DEST_LEFT:    sh_left = value & 511;
			CFG_DEST_TOP:     sh_top  = value & 511;
			CFG_RECT_WIDTH:   sh_rw   = clamp_dim(value & 1023, DEF_MAX_WIDTH);
			CFG_RECT_HEIGHT:  sh_rh   = clamp_dim(value & 1023, DEF_MAX_HEIGHT);
			default: ;
		endcase
		@(posedge clk);
	endtask

	// drain all results and any fill sweep before touching registers
	task automatic wait_idle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		while (!item_ready) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// one input transaction with random idle cycles ahead of it
	task automatic send(logic [ACT_W-1:0] act, logic [PIX_W-1:0] pix,
		logic [ADDR_W-1:0] addr);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= {act, pix, addr};
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		items_sent++;
	endtask

	// random register subset, then a mix of rectangle bursts, reads and fills
	task automatic random_phase(int n);
		int stop;
		int pick;
		int burst;
		bit wide_w;
		bit wide_h;
		stop   = items_sent + n;
		wide_w = ($urandom_range(5) == 0);
		wide_h = !wide_w && ($urandom_range(5) == 0);
		wait_idle();
		if ($urandom_range(99) < 60) set_reg(CFG_LINE_WIDTH, rand_dim(wide_w, 24));
		if ($urandom_range(99) < 60) set_reg(CFG_FRAME_HEIGHT, rand_dim(wide_h, 24));
		if ($urandom_range(99) < 60)
			set_reg(CFG_DEST_LEFT, ($urandom_range(9) == 0) ? $urandom_range(1023)
				: $urandom_range(sh_w - 1));
		if ($urandom_range(99) < 60)
			set_reg(CFG_DEST_TOP, ($urandom_range(9) == 0) ? $urandom_range(1023)
				: $urandom_range(sh_h - 1));
		if ($urandom_range(99) < 60)
			set_reg(CFG_RECT_WIDTH, rand_dim($urandom_range(11) == 0, 8));
		if ($urandom_range(99) < 60)
			set_reg(CFG_RECT_HEIGHT, rand_dim(sh_rw <= 16 && $urandom_range(11) == 0,
				(sh_rw > 16) ? 2 : 8));
		if ($urandom_range(99) < 60) set_reg(CFG_RASTER_OP, $urandom_range(7));
		if ($urandom_range(99) < 15) set_reg(CFG_SPARE, $urandom_range(1023));
		cfg_wr_en <= 1'b0;
		while (items_sent < stop) begin
			pick = $urandom_range(99);
			if (pick < 55) begin
				// whole rectangle when it is small, a slice of it otherwise
				burst = (sh_rw * sh_rh <= BURST_MAX) ? sh_rw * sh_rh
					: $urandom_range(1, BURST_MAX);
				repeat (burst) send(ACT_BLIT, rand_pixel(), $urandom);
			end else if (pick < 75) begin
				repeat ($urandom_range(1, 4)) send(ACT_READ, rand_pixel(), rect_addr());
			end else if (pick < 85) begin
				send(ACT_READ, rand_pixel(), $urandom_range(sh_w * sh_h - 1));
			end else if (pick < 91) begin
				send(ACT_READ, rand_pixel(), $urandom);
			end else if (pick < 97) begin
				if (sh_w * sh_h <= FILL_MAX) send(ACT_FILL, rand_pixel(), $urandom);
				else send(ACT_READ, rand_pixel(), rect_addr());
			end else begin
				send(ACT_NONE, $urandom, $urandom);
			end
		end
	endtask

	// stimulus and verdict
	initial begin
		int stop;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// reset state: cleared store, full frame, 1x1 copy at the origin
		send(ACT_READ, '0, '0);
		send(ACT_READ, '0, '1);
		send(ACT_BLIT, '1, '0);
		send(ACT_READ, '0, '0);
		send(ACT_NONE, '1, '1);
		send(ACT_FILL, 32'hA5A5_5A5A, '0);
		send(ACT_READ, '0, '1);

		// one-pixel-wide frame, oversize height, rectangle past the right edge
		wait_idle();
		set_reg(CFG_LINE_WIDTH, 0);
		set_reg(CFG_FRAME_HEIGHT, 1023);
		set_reg(CFG_DEST_LEFT, 511);
		set_reg(CFG_DEST_TOP, 0);
		set_reg(CFG_RECT_WIDTH, 2);
		set_reg(CFG_RECT_HEIGHT, 1);
		set_reg(CFG_RASTER_OP, ROP_OR);
		cfg_wr_en <= 1'b0;
		send(ACT_BLIT, rand_pixel(), '0);
		send(ACT_BLIT, rand_pixel(), '0);
		send(ACT_READ, '0, 18'd512);
		send(ACT_READ, '0, 18'd511);

		// every raster op code, unknown ones too, stacked on one pixel of a 4x4 frame
		wait_idle();
		set_reg(CFG_LINE_WIDTH, 4);
		set_reg(CFG_FRAME_HEIGHT, 4);
		set_reg(CFG_DEST_LEFT, 2);
		set_reg(CFG_DEST_TOP, 2);
		set_reg(CFG_RECT_WIDTH, 0);
		set_reg(CFG_RECT_HEIGHT, 0);
		cfg_wr_en <= 1'b0;
		for (int op = 0; op < 8; op++) begin
			wait_idle();
			set_reg(CFG_RASTER_OP, op);
			cfg_wr_en <= 1'b0;
			send(ACT_BLIT, rand_pixel(), '0);
		end
		send(ACT_READ, '0, 18'd10);

		// rectangle below the bottom edge
		wait_idle();
		set_reg(CFG_DEST_TOP, 511);
		cfg_wr_en <= 1'b0;
		send(ACT_BLIT, '1, '0);

		// random part: sender idles lightly, then the receiver, then neither
		for (int mode = 0; mode < 3; mode++) begin
			send_idle_pct  = (mode == 0) ? 8 : ((mode == 1) ? 62 : 0);
			recv_stall_pct = (mode == 0) ? 62 : ((mode == 1) ? 8 : 0);
			stop = items_sent + RAND_ITEMS / 3;
			while (items_sent < stop) random_phase($urandom_range(15, 60));
		end

		// drain and give the pipeline time to show stray results
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0) $display("tb: PASS");
		else $display("tb: FAIL");
		$finish;
	end

endmodule

/* raster_op_blitter_top.f */
design/rob_pkg.sv
design/rob_cfg.sv
design/rob_addr_gen.sv
design/rob_rmw.sv
design/raster_op_blitter_top.sv
tb/blit_checker.sv
tb/tb.sv
